[rtl/core/ssc_pkg.sv]
// Shared types and constants for the subset-sum counter.
`default_nettype none
package ssc_pkg;
    localparam int MAX_ITEMS_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;
    localparam int TARGET_BITS    = 48;
    localparam int COUNT_BITS     = 16;
    localparam int CHOSEN_BITS    = 5;

    // Register indexes on the configuration port, one register per 8 bytes.
    localparam logic REG_TARGET = 1'b0;
    localparam logic REG_CHOSEN = 1'b1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic clear_total;   // zero match total
        logic load_remain;   // compute remainder and chosen checks
        logic clr_sel;       // restart subset selector
        logic step_sel;      // advance subset selector
        logic acc_clr;       // clear running subset sum
        logic acc_step;      // add one item into running sum
        logic wr_left;       // write finished sum into left table
        logic wr_right;      // write finished sum into right table
        logic rd_addr_sel;   // table read address select
        logic cmp_step;      // compare and count
    } ssc_cmd_t;

    typedef struct packed {
        logic bad;           // chosen index or value makes count zero
        logic bit_done;      // running sum covered all items of half
        logic sel_done;      // all subsets of half enumerated
        logic pair_done;     // every left sum paired with every right sum
    } ssc_stat_t;
endpackage
`default_nettype wire

[rtl/core/subset_sum_count_mitm.sv]
// Top level of the meet-in-the-middle subset-sum counter.
// Items load one per cycle while in_stall is low; the request marked last
// starts a count over the stored items, using one shared adder to build each
// subset sum and a single-port table walk pairing left and right sums. No
// request is taken while a count runs; the result sits in an output register
// until taken, and the next set may load while it waits.
`default_nettype none
module subset_sum_count_mitm
    import ssc_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:3]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic      [63:0]  prdata,
    output logic              pready,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire logic [31:0]  item_value,
    input  wire logic         last_item,
    output logic              out_valid,
    input  wire logic         out_stall,
    output logic      [15:0]  subset_count
);
    localparam int IB = $clog2(MAX_ITEMS+1);

    logic [TARGET_BITS-1:0] target_reg;
    logic [CHOSEN_BITS-1:0] chosen_reg;
    logic [IB-1:0] cnt_reg;
    logic out_valid_reg;
    logic [COUNT_BITS-1:0] out_reg;
    logic start_reg;
    logic busy, done, accept, wr;
    ssc_cmd_t  cmd;
    ssc_stat_t stat;
    logic [COUNT_BITS-1:0] count;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    // Hold off input from the last request until the count has started.
    assign in_stall = busy || start_reg;
    assign accept  = in_valid && !in_stall;

    // Target at byte address 0; chosen index at 8.
    always_comb
    begin
        case (paddr)
            REG_TARGET: prdata = 64'(target_reg);
            REG_CHOSEN: prdata = 64'(chosen_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg    <= '0;
            chosen_reg    <= CHOSEN_BITS'(1);
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr && paddr == REG_TARGET)
                target_reg <= pwdata[TARGET_BITS-1:0];
            if (wr && paddr == REG_CHOSEN)
                chosen_reg <= pwdata[CHOSEN_BITS-1:0];
            if (accept && cnt_reg < IB'(MAX_ITEMS))
                cnt_reg <= cnt_reg + 1'b1;
            if (done)
                cnt_reg <= '0;
            if (done)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_reg <= count;
    end

    assign out_valid    = out_valid_reg;
    assign subset_count = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= 1'b0;
        else
            start_reg <= accept && last_item;
    end

    ssc_datapath #(.MAX_ITEMS(MAX_ITEMS), .VALUE_BITS(VALUE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .item_we(accept), .item_wdata(VALUE_BITS'(item_value)),
        .item_cnt(cnt_reg), .target_sum(target_reg), .chosen_index(chosen_reg),
        .cmd(cmd), .stat(stat), .count(count));

    ssc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start_reg), .out_free(!out_valid_reg),
        .stat(stat), .cmd(cmd), .busy(busy), .done(done));
endmodule
`default_nettype wire

[rtl/core/ssc_ram.sv]
// Generic single-port RAM with registered read.
`default_nettype none
module ssc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[rtl/core/ssc_datapath.sv]
// Datapath: item store, subset sum enumeration and pairwise match count.
`default_nettype none
module ssc_datapath
    import ssc_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_we,
    input  wire logic [VALUE_BITS-1:0]   item_wdata,
    input  wire logic [$clog2(MAX_ITEMS+1)-1:0] item_cnt,
    input  wire logic [TARGET_BITS-1:0]  target_sum,
    input  wire logic [CHOSEN_BITS-1:0]  chosen_index,
    input  wire ssc_cmd_t                cmd,
    output ssc_stat_t                    stat,
    output logic [COUNT_BITS-1:0]        count
);
    localparam int IB    = $clog2(MAX_ITEMS+1);
    localparam int IDXB  = $clog2(MAX_ITEMS);
    localparam int HALF  = MAX_ITEMS / 2;
    localparam int DEPTH = 1 << HALF;
    localparam int AB    = HALF;
    localparam int SELB  = $clog2(HALF+1);
    localparam int SB    = VALUE_BITS + IB;
    localparam int TB    = (SB > TARGET_BITS) ? SB : TARGET_BITS;
    localparam int CW    = (IB > CHOSEN_BITS) ? IB : CHOSEN_BITS;

    logic [VALUE_BITS-1:0] store_reg [MAX_ITEMS];
    logic [VALUE_BITS-1:0] others [MAX_ITEMS];
    logic [IB-1:0] m, lcnt, rcnt;
    logic [TB:0] remain_reg, remain_next;
    logic bad_reg, bad_next;
    logic [HALF:0] sel_reg;       // subset index, one spare bit flags wrap
    logic [IB-1:0] bit_reg;       // item index inside current subset sum
    logic [SB-1:0] acc_reg;
    logic phase_reg;              // 0: left half, 1: right half
    logic [HALF:0] li_reg, ri_reg;
    logic [COUNT_BITS:0] total_reg;
    logic [SB-1:0] lrd, rrd;
    logic [AB-1:0] laddr, raddr;
    logic [IB-1:0] half_cnt;
    logic [IB-1:0] item_pos;
    logic [IDXB-1:0] ci;

    always_ff @(posedge clk)
    begin
        if (item_we && item_cnt < IB'(MAX_ITEMS))
        begin
            store_reg[item_cnt[IDXB-1:0]] <= item_wdata;
        end
    end

    // Compact the items other than the chosen one.
    always_comb
    begin
        ci = IDXB'(chosen_index - 5'd1);
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            if (i < int'(ci))
                others[i] = store_reg[i];
            else if (i < MAX_ITEMS - 1)
                others[i] = store_reg[i+1];
            else
                others[i] = '0;
        end
        m    = item_cnt - IB'(1);
        lcnt = m >> 1;
        rcnt = m - lcnt;
    end

    always_comb
    begin
        bad_next    = bad_reg;
        remain_next = remain_reg;
        if (cmd.load_remain)
        begin
            bad_next = (chosen_index == '0) || (CW'(chosen_index) > CW'(item_cnt));
            remain_next = (TB+1)'(target_sum) - (TB+1)'(store_reg[ci]);
            if (remain_next[TB])
                bad_next = 1'b1;
        end
    end

    assign half_cnt = phase_reg ? rcnt : lcnt;
    assign item_pos = phase_reg ? (lcnt + bit_reg) : bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bad_reg   <= 1'b0;
            sel_reg   <= '0;
            bit_reg   <= '0;
            phase_reg <= 1'b0;
            li_reg    <= '0;
            ri_reg    <= '0;
            total_reg <= '0;
        end
        else
        begin
            bad_reg <= bad_next;
            if (cmd.clr_sel)
            begin
                sel_reg <= '0;
                phase_reg <= cmd.wr_right;
            end
            else if (cmd.step_sel)
            begin
                sel_reg <= sel_reg + 1'b1;
            end
            if (cmd.acc_clr)
                bit_reg <= '0;
            else if (cmd.acc_step)
                bit_reg <= bit_reg + 1'b1;
            if (cmd.clear_total)
            begin
                total_reg <= '0;
                li_reg    <= '0;
                ri_reg    <= '0;
            end
            else if (cmd.cmp_step)
            begin
                // Pair walk: compare table outputs, then advance indexes.
                if (ri_reg == (HALF+1)'(1) << rcnt)
                begin
                    li_reg <= li_reg + 1'b1;
                    ri_reg <= '0;
                end
                else
                begin
                    ri_reg <= ri_reg + 1'b1;
                end
            end
            if (cmd.cmp_step && ri_reg != '0 && ri_reg <= (HALF+1)'(1) << rcnt
                && (TB+1)'(lrd) + (TB+1)'(rrd) == remain_reg
                && !total_reg[COUNT_BITS])
            begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.acc_step && sel_reg[bit_reg[SELB-1:0]])
            acc_reg <= acc_reg + SB'(others[item_pos[IDXB-1:0]]);
    end

    // Walk both tables when matching: left index fixed while right index sweeps; else both use the subset index.
    assign laddr = cmd.rd_addr_sel ? li_reg[AB-1:0] : sel_reg[AB-1:0];
    assign raddr = cmd.rd_addr_sel ? ri_reg[AB-1:0] : sel_reg[AB-1:0];

    ssc_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_left (
        .clk(clk), .we(cmd.wr_left), .addr(laddr), .wdata(acc_reg), .rdata(lrd));
    ssc_ram #(.WIDTH(SB), .DEPTH(DEPTH)) u_right (
        .clk(clk), .we(cmd.wr_right && !cmd.clr_sel), .addr(raddr),
        .wdata(acc_reg), .rdata(rrd));

    always_comb
    begin
        stat.bad       = bad_reg;
        stat.bit_done  = (bit_reg >= half_cnt);
        stat.sel_done  = (sel_reg == (HALF+1)'(1) << half_cnt);
        stat.pair_done = (li_reg == (HALF+1)'(1) << lcnt);
        count = total_reg[COUNT_BITS] ? '1 : total_reg[COUNT_BITS-1:0];
    end
endmodule
`default_nettype wire

[rtl/core/ssc_ctrl.sv]
// Controller state machine sequencing load, enumeration and match phases.
`default_nettype none
module ssc_ctrl
    import ssc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      out_free,
    input  wire ssc_stat_t stat,
    output ssc_cmd_t       cmd,
    output logic           busy,
    output logic           done
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_CHK   = 8'b00000010,
        S_LSUM  = 8'b00000100,
        S_LWR   = 8'b00001000,
        S_RSUM  = 8'b00010000,
        S_RWR   = 8'b00100000,
        S_MATCH = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done       = 1'b0;
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_remain = 1'b1;
                    cmd.clear_total = 1'b1;
                    cmd.clr_sel     = 1'b1;
                    cmd.acc_clr     = 1'b1;
                    state_next      = S_CHK;
                end
            end
            S_CHK:
            begin
                state_next = stat.bad ? S_DONE : S_LSUM;
            end
            S_LSUM:
            begin
                if (stat.sel_done)
                begin
                    cmd.clr_sel  = 1'b1;
                    cmd.wr_right = 1'b1;
                    cmd.acc_clr  = 1'b1;
                    state_next   = S_RSUM;
                end
                else if (stat.bit_done)
                    state_next = S_LWR;
                else
                    cmd.acc_step = 1'b1;
            end
            S_LWR:
            begin
                cmd.wr_left  = 1'b1;
                cmd.step_sel = 1'b1;
                cmd.acc_clr  = 1'b1;
                state_next   = S_LSUM;
            end
            S_RSUM:
            begin
                if (stat.sel_done)
                begin
                    cmd.rd_addr_sel = 1'b1;
                    state_next      = S_MATCH;
                end
                else if (stat.bit_done)
                    state_next = S_RWR;
                else
                    cmd.acc_step = 1'b1;
            end
            S_RWR:
            begin
                cmd.wr_right = 1'b1;
                cmd.step_sel = 1'b1;
                cmd.acc_clr  = 1'b1;
                state_next   = S_RSUM;
            end
            S_MATCH:
            begin
                cmd.rd_addr_sel = 1'b1;
                if (stat.pair_done)
                    state_next = S_DONE;
                else
                    cmd.cmp_step = 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

[sim/subset_sum_count_mitm_tb.sv]
// Testbench for the meet-in-the-middle subset-sum counter: sets, registers, stalls.
`timescale 1ns / 1ps
module subset_sum_count_mitm_tb;
    import ssc_pkg::*;

    localparam int         STORE_DEPTH   = MAX_ITEMS_DEF;
    localparam int         SET_MAX       = 32;
    localparam int         EXP_DEPTH     = 64;
    localparam longint     CYCLE_LIMIT   = 4000000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:3]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] item_value;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] subset_count;

    logic [TARGET_BITS-1:0] cur_target;
    logic [CHOSEN_BITS-1:0] cur_chosen;
    logic [31:0]            loaded_vals[STORE_DEPTH];
    int                     loaded_len;
    logic [15:0]            exp_counts[EXP_DEPTH];
    int                     exp_wr;
    int                     exp_rd;
    logic [31:0]            set_vals[SET_MAX];
    int                     set_len;
    int                     fail_cnt;
    int                     hold_len;
    longint                 cycle_cnt;

    subset_sum_count_mitm dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .item_value(item_value), .last_item(last_item),
        .out_valid(out_valid), .out_stall(out_stall), .subset_count(subset_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("subset_sum_count_mitm test failed");
            $finish;
        end
    end

    // Brute-force count over the stored items, chosen item forced in.
    function automatic logic [15:0] count_matches(input logic [TARGET_BITS-1:0] tgt,
                                                  input logic [CHOSEN_BITS-1:0] chosen);
        logic [63:0] others[STORE_DEPTH];
        logic [63:0] remain;
        logic [63:0] acc;
        int          n;
        int          m;
        longint      hits;
        n = (loaded_len > STORE_DEPTH) ? STORE_DEPTH : loaded_len;
        m = 0;
        hits = 0;
        if (chosen == 0 || chosen > n)
            return 16'd0;
        if (64'(loaded_vals[chosen-1]) > 64'(tgt))
            return 16'd0;
        remain = 64'(tgt) - 64'(loaded_vals[chosen-1]);
        for (int i = 0; i < n; i++)
            if (i != chosen - 1)
            begin
                others[m] = 64'(loaded_vals[i]);
                m++;
            end
        for (int sel = 0; sel < (1 << m); sel++)
        begin
            acc = 0;
            for (int b = 0; b < m; b++)
                if (sel[b])
                    acc += others[b];
            if (acc == remain)
                hits++;
        end
        return (hits > 65535) ? 16'hFFFF : 16'(hits);
    endfunction

    task automatic reg_write(input logic idx, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= idx;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Wait until every result is back, then write the registers.
    task automatic configure(input logic [TARGET_BITS-1:0] tgt,
                             input logic [CHOSEN_BITS-1:0] chosen);
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
        reg_write(REG_TARGET, 64'(tgt));
        reg_write(REG_CHOSEN, 64'(chosen));
        cur_target = tgt;
        cur_chosen = chosen;
    endtask

    task automatic send_request(input logic [31:0] val, input logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        item_value <= val;
        last_item  <= last;
        do
            @(posedge clk);
        while (in_stall);
        if (loaded_len < STORE_DEPTH)
            loaded_vals[loaded_len] = val;
        loaded_len++;
        if (last)
        begin
            exp_counts[exp_wr % EXP_DEPTH] = count_matches(cur_target, cur_chosen);
            exp_wr++;
            loaded_len = 0;
        end
    endtask

    task automatic set_clear();
        set_len = 0;
    endtask

    task automatic set_add(input logic [31:0] val);
        set_vals[set_len] = val;
        set_len++;
    endtask

    task automatic send_set();
        for (int i = 0; i < set_len; i++)
            send_request(set_vals[i], i == set_len - 1);
    endtask

    function automatic logic [31:0] draw_value(input int mode);
        case (mode)
            0: return $urandom_range(0, 7);
            1: return $urandom_range(0, 65535);
            2: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // Sum of a random subset that holds the chosen item when it is in range, so counts are then nonzero.
    function automatic logic [TARGET_BITS-1:0] reachable_target(input int chosen);
        logic [TARGET_BITS-1:0] t;
        int n;
        n = (set_len > STORE_DEPTH) ? STORE_DEPTH : set_len;
        t = 0;
        for (int i = 0; i < n; i++)
            if (i == chosen - 1 || $urandom_range(0, 1) != 0)
                t += TARGET_BITS'(set_vals[i]);
        return t;
    endfunction

    task automatic test_directed();
        configure(48'd0, 5'd1);
        set_clear();
        set_add(32'd0);
        set_add(32'd0);
        set_add(32'd0);
        send_set();
        set_clear();
        set_add(32'd5);
        send_set();
        configure(48'hFFFF_FFFF_FFFF, 5'd16);
        set_clear();
        repeat (16) set_add(32'hFFFF_FFFF);
        send_set();
        // chosen item beyond the loaded count
        set_clear();
        set_add(32'd1);
        set_add(32'd2);
        send_set();
        configure(48'd3, 5'd0);
        set_clear();
        set_add(32'd1);
        set_add(32'd2);
        set_add(32'd3);
        send_set();
        configure(48'd3, 5'd31);
        send_set();
        // chosen value above the target
        configure(48'd4, 5'd2);
        set_clear();
        set_add(32'd1);
        set_add(32'd9);
        set_add(32'd4);
        send_set();
        // extra items past the store are dropped
        configure(48'd10, 5'd1);
        set_clear();
        repeat (19) set_add(32'd1);
        send_set();
        configure(48'h1_0000_0000, 5'd2);
        set_clear();
        set_add(32'hFFFF_FFFF);
        set_add(32'd1);
        set_add(32'h8000_0000);
        set_add(32'h7FFF_FFFF);
        set_add(32'd0);
        send_set();
    endtask

    task automatic test_random();
        int mode;
        int len;
        int sent;
        int big_sets;
        int chosen;
        sent = 0;
        big_sets = 0;
        while (sent < 780)
        begin
            case ($urandom_range(0, 19))
                0: len = (big_sets < 5) ? $urandom_range(15, 20) : $urandom_range(1, 6);
                1, 2: len = $urandom_range(7, 11);
                default: len = $urandom_range(1, 6);
            endcase
            if (len >= 15)
                big_sets++;
            mode = $urandom_range(0, 4);
            set_clear();
            repeat (len) set_add(draw_value(mode));
            if ($urandom_range(0, 9) < 7)
            begin
                chosen = $urandom_range(0, 9) == 0 ? $urandom_range(0, 31)
                                                  : $urandom_range(1, (len > 16) ? 16 : len);
                if ($urandom_range(0, 4) == 0)
                    configure(48'({$urandom, $urandom}), 5'(chosen));
                else
                    configure(reachable_target(chosen), 5'(chosen));
            end
            send_set();
            sent += len;
        end
    endtask

    task automatic test_backpressure();
        configure(48'd6, 5'd1);
        hold_len = 400;
        repeat (12)
        begin
            set_clear();
            repeat ($urandom_range(1, 5)) set_add(draw_value(0));
            send_set();
        end
    endtask

    // Result side: draw a stall per result, or honor a long hold-off.
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_len > 0)
            begin
                n = hold_len;
                hold_len = 0;
            end
            else
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            if (exp_wr == exp_rd)
            begin
                $error("unexpected result subset_count=%0d", subset_count);
                fail_cnt++;
            end
            else
            begin
                if (subset_count !== exp_counts[exp_rd % EXP_DEPTH])
                begin
                    $error("subset_count expected %0d actual %0d",
                           exp_counts[exp_rd % EXP_DEPTH], subset_count);
                    fail_cnt++;
                end
                exp_rd++;
            end
        end
    end

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        item_value = '0;
        last_item  = 1'b0;
        fail_cnt   = 0;
        hold_len   = 0;
        cycle_cnt  = 0;
        loaded_len = 0;
        exp_wr     = 0;
        exp_rd     = 0;
        set_len    = 0;
        cur_target = '0;
        cur_chosen = 5'd1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_cnt == 0)
            $display("subset_sum_count_mitm test passed");
        else
            $display("subset_sum_count_mitm test failed");
        $finish;
    end
endmodule
